>>> rtl/core/fmr_pkg.sv
// Shared types and constants for the framed message receiver.
// No dependencies; imported by every module of the block.
package fmr_pkg;

    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int WIDX_W     = 6;
    localparam int COUNT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // input item modes
    localparam logic [MODE_W-1:0] MODE_RX_BYTE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET_PEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ARM_ACK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTS_NEEDED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_GOOD      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_BAD       = 2'd3;

    // configuration reset values
    localparam logic [BYTE_W-1:0]  RST_START_BYTE    = 8'd94;
    localparam logic [COUNT_W-1:0] RST_STARTS_NEEDED = 2'd3;
    localparam logic [BYTE_W-1:0]  RST_ACK_GOOD      = 8'd6;
    localparam logic [BYTE_W-1:0]  RST_ACK_BAD       = 8'd21;

    // start counter saturation
    localparam logic [COUNT_W-1:0] START_COUNT_MAX = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] rx_byte;
        logic              pending_value;
    } t_in_item;

    typedef struct packed {
        logic              write_valid;
        logic [WIDX_W-1:0] write_index;
        logic [BYTE_W-1:0] write_byte;
        logic              message_pending;
        logic              ack_seen;
        logic              nack_seen;
        logic              waiting_ack;
        logic              overflow;
    } t_out_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  start_byte;
        logic [COUNT_W-1:0] starts_needed;
        logic [BYTE_W-1:0]  ack_good_byte;
        logic [BYTE_W-1:0]  ack_bad_byte;
    } t_cfg;

endpackage

>>> rtl/core/fmr_cfg_regs.sv
// Configuration register file of the framed message receiver.
// Depends on fmr_pkg.
module fmr_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fmr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fmr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output fmr_pkg::t_cfg                     o_cfg
);
    import fmr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= RST_START_BYTE;
            r_cfg.starts_needed <= RST_STARTS_NEEDED;
            r_cfg.ack_good_byte <= RST_ACK_GOOD;
            r_cfg.ack_bad_byte  <= RST_ACK_BAD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_BYTE:    r_cfg.start_byte    <= i_cfg_wdata;
                CFG_STARTS_NEEDED: r_cfg.starts_needed <= i_cfg_wdata[COUNT_W-1:0];
                CFG_ACK_GOOD:      r_cfg.ack_good_byte <= i_cfg_wdata;
                CFG_ACK_BAD:       r_cfg.ack_bad_byte  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/fmr_in_reg.sv
// Input register stage: holds one accepted item until the engine takes it.
// Depends on fmr_pkg.
module fmr_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fmr_pkg::t_in_item i_in_data,
    output logic              o_item_valid,
    output fmr_pkg::t_in_item o_item,
    input  logic              i_take
);
    import fmr_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_in_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

>>> rtl/core/fmr_engine.sv
// Framing state and decision logic with the result register.
// Depends on fmr_pkg.
module fmr_engine #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fmr_pkg::t_cfg      i_cfg,
    input  logic               i_item_valid,
    input  fmr_pkg::t_in_item  i_item,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fmr_pkg::t_out_item o_out_data
);
    import fmr_pkg::*;

    localparam int POS_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BUFFER_DEPTH);

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    t_phase             r_phase,       n_phase;
    logic [COUNT_W-1:0] r_start_count, n_start_count;
    logic [BYTE_W-1:0]  r_bytes_left,  n_bytes_left;
    logic [POS_W-1:0]   r_write_pos,   n_write_pos;
    logic               r_pending,     n_pending;
    logic               r_ack_wait,    n_ack_wait;
    logic               r_out_valid;
    t_out_item          r_out,         n_out;

    logic [COUNT_W-1:0] need;
    logic [COUNT_W-1:0] count_bumped;
    logic               is_start;

    // advance when the result slot is free or being drained
    assign o_take = i_item_valid && (!r_out_valid || i_out_ready);

    assign need     = (i_cfg.starts_needed == '0) ? COUNT_W'(1) : i_cfg.starts_needed;
    assign is_start = (i_item.rx_byte == i_cfg.start_byte)
                      && (r_start_count != START_COUNT_MAX);
    assign count_bumped = is_start ? COUNT_W'(r_start_count + 1'b1) : r_start_count;

    always_comb begin
        n_phase       = r_phase;
        n_start_count = r_start_count;
        n_bytes_left  = r_bytes_left;
        n_write_pos   = r_write_pos;
        n_pending     = r_pending;
        n_ack_wait    = r_ack_wait;
        n_out         = '0;

        case (i_item.mode)
            MODE_SET_PEND: n_pending = i_item.pending_value;
            MODE_ARM_ACK:  n_ack_wait = 1'b1;
            MODE_RX_BYTE: begin
                case (r_phase)
                    PH_LENGTH: begin
                        n_bytes_left      = i_item.rx_byte;
                        n_out.write_valid = 1'b1;
                        n_out.write_byte  = i_item.rx_byte;
                        n_write_pos       = POS_W'(1);
                        n_phase           = PH_BODY;
                    end
                    PH_BODY: begin
                        if (r_ack_wait) begin
                            if (i_item.rx_byte == i_cfg.ack_good_byte) begin
                                n_out.ack_seen = 1'b1;
                                n_ack_wait     = 1'b0;
                                n_phase        = PH_START;
                            end else if (i_item.rx_byte == i_cfg.ack_bad_byte) begin
                                n_out.nack_seen = 1'b1;
                            end
                        end else if (r_bytes_left != '0) begin
                            n_bytes_left = r_bytes_left - 1'b1;
                            if (r_write_pos < POS_LIMIT) begin
                                n_out.write_valid = 1'b1;
                                n_out.write_index = WIDX_W'(r_write_pos);
                                n_out.write_byte  = i_item.rx_byte;
                                n_write_pos       = POS_W'(r_write_pos + 1'b1);
                            end else begin
                                n_out.overflow = 1'b1;
                            end
                        end else begin
                            // byte after the payload closes the frame
                            n_pending   = 1'b1;
                            n_phase     = PH_START;
                            n_write_pos = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_START;
                        if (!r_pending) begin
                            n_start_count = count_bumped;
                            if (count_bumped >= need) begin
                                n_phase       = PH_LENGTH;
                                n_start_count = '0;
                            end
                        end
                    end
                endcase
            end
            default: ;
        endcase

        n_out.message_pending = n_pending;
        n_out.waiting_ack     = n_ack_wait;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_start_count <= '0;
            r_bytes_left  <= '0;
            r_write_pos   <= '0;
            r_pending     <= 1'b0;
            r_ack_wait    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase       <= n_phase;
                r_start_count <= n_start_count;
                r_bytes_left  <= n_bytes_left;
                r_write_pos   <= n_write_pos;
                r_pending     <= n_pending;
                r_ack_wait    <= n_ack_wait;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_pos <= POS_LIMIT)
        else $error("write position past buffer depth");

    a_write_xor_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.write_valid && r_out.overflow))
        else $error("store and overflow in one result");

    a_ack_clears_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ack_seen) |-> (!r_out.waiting_ack && r_phase == PH_START))
        else $error("ack did not release the wait");

    a_start_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_START) |-> (r_start_count == '0))
        else $error("start count held outside the start phase");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out))
        else $error("result changed while stalled");

endmodule

>>> rtl/core/framed_message_receiver.sv
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while the output accepts results; the framing
// decision is a single combinational pass between the input register and the
// result register.
// One result per item. Synchronous active-low reset clears framing state and flags
// and loads the default configuration; no clearing pass is needed.
module framed_message_receiver #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  fmr_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output fmr_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [fmr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fmr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import fmr_pkg::*;

    t_cfg     cfg;
    logic     item_valid;
    t_in_item item;
    logic     take;

    fmr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    fmr_in_reg u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_take       (take)
    );

    fmr_engine #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for framed_message_receiver: a scoreboard class tracks framing state
// and checks each result in order; tasks drive items and register writes, and a receiver process drives output stalls.
// Depends on fmr_pkg and the framed_message_receiver RTL.
import fmr_pkg::*;

typedef enum logic [1:0] {
    FRM_HUNT   = 2'd0,
    FRM_LENGTH = 2'd1,
    FRM_BODY   = 2'd2
} frame_phase_e;

class frame_scoreboard;
    int unsigned        depth;
    t_cfg               regs;
    frame_phase_e       phase;
    logic [COUNT_W-1:0] start_seen;
    logic [BYTE_W-1:0]  len_left;
    int unsigned        buf_pos;
    logic               msg_pending;
    logic               ack_armed;
    t_out_item          expected_steps[$];
    int                 errors;

    function new(int unsigned depth_p);
        depth = depth_p;
        regs.start_byte = RST_START_BYTE;
        regs.starts_needed = RST_STARTS_NEEDED;
        regs.ack_good_byte = RST_ACK_GOOD;
        regs.ack_bad_byte = RST_ACK_BAD;
        phase = FRM_HUNT;
        start_seen = '0;
        len_left = '0;
        buf_pos = 0;
        msg_pending = 1'b0;
        ack_armed = 1'b0;
        errors = 0;
    endfunction

    function int outstanding();
        return expected_steps.size();
    endfunction

    // advance the framing state by one accepted transfer and queue its result
    function void accept_item(t_in_item it);
        t_out_item          r;
        logic [COUNT_W-1:0] need;
        r = '0;
        case (it.mode)
            MODE_SET_PEND: msg_pending = it.pending_value;
            MODE_ARM_ACK:  ack_armed = 1'b1;
            MODE_RX_BYTE: begin
                case (phase)
                    FRM_LENGTH: begin
                        len_left = it.rx_byte;
                        r.write_valid = 1'b1;
                        r.write_index = '0;
                        r.write_byte = it.rx_byte;
                        buf_pos = 1;
                        phase = FRM_BODY;
                    end
                    FRM_BODY: begin
                        if (ack_armed) begin
                            if (it.rx_byte == regs.ack_good_byte) begin
                                r.ack_seen = 1'b1;
                                ack_armed = 1'b0;
                                phase = FRM_HUNT;
                            end else if (it.rx_byte == regs.ack_bad_byte) begin
                                r.nack_seen = 1'b1;
                            end
                        end else if (len_left != '0) begin
                            len_left = len_left - 1'b1;
                            if (buf_pos < depth) begin
                                r.write_valid = 1'b1;
                                r.write_index = WIDX_W'(buf_pos);
                                r.write_byte = it.rx_byte;
                                buf_pos++;
                            end else begin
                                r.overflow = 1'b1;
                            end
                        end else begin
                            // trailing byte closes the frame, not stored
                            msg_pending = 1'b1;
                            phase = FRM_HUNT;
                            buf_pos = 0;
                        end
                    end
                    default: begin
                        phase = FRM_HUNT;
                        if (!msg_pending) begin
                            need = (regs.starts_needed == '0) ? COUNT_W'(1) : regs.starts_needed;
                            if (it.rx_byte == regs.start_byte && start_seen < START_COUNT_MAX)
                                start_seen = start_seen + 1'b1;
                            if (start_seen >= need) begin
                                phase = FRM_LENGTH;
                                start_seen = '0;
                            end
                        end
                    end
                endcase
            end
            default: ;
        endcase
        r.message_pending = msg_pending;
        r.waiting_ack = ack_armed;
        expected_steps.push_back(r);
    endfunction

    function void cmp_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (expected_steps.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            errors++;
            return;
        end
        want = expected_steps.pop_front();
        cmp_field("write_valid", want.write_valid, got.write_valid);
        cmp_field("write_index", want.write_index, got.write_index);
        cmp_field("write_byte", want.write_byte, got.write_byte);
        cmp_field("message_pending", want.message_pending, got.message_pending);
        cmp_field("ack_seen", want.ack_seen, got.ack_seen);
        cmp_field("nack_seen", want.nack_seen, got.nack_seen);
        cmp_field("waiting_ack", want.waiting_ack, got.waiting_ack);
        cmp_field("overflow", want.overflow, got.overflow);
    endfunction
endclass

module tb_top;
    localparam int BUF_DEPTH       = 64;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_ITEMS    = 650;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    frame_scoreboard sb;
    t_cfg            cur_cfg;
    int unsigned     n_sent = 0;
    int unsigned     idle_cycles = 0;
    bit              no_gaps = 1'b0;
    bit              hold_req = 1'b0;

    always #4 clk = ~clk;

    framed_message_receiver #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("framed_message_receiver: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] edge_or_random_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_cfg make_cfg(logic [7:0] sbyte, logic [1:0] needed,
                                      logic [7:0] good, logic [7:0] bad);
        t_cfg c;
        c.start_byte = sbyte;
        c.starts_needed = needed;
        c.ack_good_byte = good;
        c.ack_bad_byte = bad;
        return c;
    endfunction

    function automatic int unsigned frame_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 92)
            return $urandom_range(0, 8);
        return $urandom_range(60, 80);
    endfunction

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned run;
        int unsigned gap;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
                gap = pick_gap();
                out_ready <= 1'b1;
                repeat (run) @(posedge clk);
                if (gap != 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // returns at the edge of the transfer with valid still high
    task automatic push_item(input logic [MODE_W-1:0] mode, input logic [7:0] b,
                             input logic pv);
        t_in_item    it;
        int unsigned gap;
        it.mode = mode;
        it.rx_byte = b;
        it.pending_value = pv;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        sb.accept_item(it);
        n_sent++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(MODE_RX_BYTE, b, 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input t_cfg c);
        cfg_we <= 1'b1;
        cfg_index <= CFG_START_BYTE;
        cfg_wdata <= c.start_byte;
        @(posedge clk);
        cfg_index <= CFG_STARTS_NEEDED;
        cfg_wdata <= CFG_DATA_W'(c.starts_needed);
        @(posedge clk);
        cfg_index <= CFG_ACK_GOOD;
        cfg_wdata <= c.ack_good_byte;
        @(posedge clk);
        cfg_index <= CFG_ACK_BAD;
        cfg_wdata <= c.ack_bad_byte;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.regs = c;
        cur_cfg = c;
    endtask

    task automatic send_frame(input int unsigned len, input bit with_ack);
        int unsigned need;
        if ($urandom_range(0, 4) != 0)
            push_item(MODE_SET_PEND, 8'($urandom), 1'b0);
        if (with_ack)
            push_item(MODE_ARM_ACK, 8'($urandom), 1'($urandom_range(0, 1)));
        need = (cur_cfg.starts_needed == '0) ? 1 : cur_cfg.starts_needed;
        repeat (need) begin
            if ($urandom_range(0, 3) == 0)
                push_byte(cur_cfg.start_byte + 8'($urandom_range(1, 255)));
            push_byte(cur_cfg.start_byte);
        end
        push_byte(8'(len));
        if (with_ack) begin
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
            if ($urandom_range(0, 1))
                push_byte(cur_cfg.ack_bad_byte);
            push_byte(cur_cfg.ack_good_byte);
        end else begin
            repeat (len) push_byte(8'($urandom));
            push_byte(8'($urandom));
        end
    endtask

    task automatic send_noise(input int unsigned n);
        logic [7:0] b;
        repeat (n) begin
            case ($urandom_range(0, 5))
                0: b = cur_cfg.start_byte;
                1: b = cur_cfg.ack_good_byte;
                2: b = cur_cfg.ack_bad_byte;
                default: b = 8'($urandom);
            endcase
            push_item(MODE_W'($urandom_range(0, 3)), b, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int unsigned directed_items;
        int unsigned k;
        int unsigned r;
        t_cfg        c;
        sb = new(BUF_DEPTH);
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_config(make_cfg(RST_START_BYTE, RST_STARTS_NEEDED, RST_ACK_GOOD, RST_ACK_BAD));
        push_item(MODE_UNUSED, 8'hFF, 1'b1);
        push_byte(8'h00);
        push_byte(RST_START_BYTE);
        push_byte(8'hFF);
        push_byte(RST_START_BYTE);
        push_byte(RST_START_BYTE);
        push_byte(8'd2);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h5A);
        // starts are not counted while a message is pending
        push_byte(RST_START_BYTE);
        push_item(MODE_SET_PEND, 8'h00, 1'b0);
        push_item(MODE_ARM_ACK, 8'hFF, 1'b1);
        push_byte(RST_ACK_GOOD);
        repeat (3) push_byte(RST_START_BYTE);
        push_byte(8'd0);
        push_byte(8'h33);
        push_byte(RST_ACK_BAD);
        push_byte(RST_ACK_GOOD);
        // leave two starts counted, then drop the requirement to one
        push_byte(RST_START_BYTE);
        push_byte(RST_START_BYTE);
        drain();
        apply_config(make_cfg(8'h00, 2'd1, 8'hFF, 8'h00));
        push_byte(8'h77);
        push_byte(8'd1);
        push_byte(8'hA5);
        push_byte(8'h00);
        push_item(MODE_SET_PEND, 8'hFF, 1'b1);
        push_item(MODE_SET_PEND, 8'h00, 1'b0);
        drain();
        apply_config(make_cfg(8'hFF, 2'd0, 8'h00, 8'hFF));
        directed_items = n_sent;

        k = 0;
        while (n_sent < directed_items + RANDOM_ITEMS) begin
            k++;
            no_gaps = ($urandom_range(0, 5) == 0);
            if (k % 12 == 0) begin
                drain();
                c = make_cfg(edge_or_random_byte(), 2'($urandom_range(0, 3)),
                             edge_or_random_byte(), edge_or_random_byte());
                if ($urandom_range(0, 7) == 0)
                    c.ack_bad_byte = c.ack_good_byte;
                apply_config(c);
            end
            if (k == 3) begin
                send_frame(255, 1'b0);
            end else if (k == 8) begin
                // output held off while a back-to-back frame keeps coming
                in_valid <= 1'b0;
                hold_req = 1'b1;
                while (hold_req) @(posedge clk);
                no_gaps = 1'b1;
                send_frame(20, 1'b0);
            end else begin
                r = $urandom_range(0, 19);
                if (r < 3)
                    send_noise($urandom_range(3, 12));
                else
                    send_frame(frame_len(), r < 10);
            end
        end

        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("framed_message_receiver: match");
        else
            $display("framed_message_receiver: mismatch");
        $finish;
    end
endmodule
